// File: rtl/cwsn_pkg.sv
// shared types, character codes and helpers for the code word string normalizer
package cwsn_pkg;

  localparam int unsigned ResMax = 3;
  localparam int unsigned CntW   = $clog2(ResMax + 1);

  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChZero      = 8'h30;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       end_of_string;
  } res_t;

  typedef res_t [ResMax-1:0] res_vec_t;

  typedef struct packed {
    logic had_output;
    logic space_pending;
    logic at_word_start;
    logic zero_pending;
  } state_t;

  localparam state_t StateReset = '{
    had_output:    1'b0,
    space_pending: 1'b0,
    at_word_start: 1'b1,
    zero_pending:  1'b0
  };

  function automatic logic is_delim(input logic [7:0] ch);
    is_delim = (ch == ChNewline) || (ch == ChComma) ||
               (ch == ChSemicolon) || (ch == ChSpace);
  endfunction

  function automatic res_vec_t put_res(input res_vec_t vec, input logic [CntW-1:0] cnt,
                                       input res_t r);
    res_vec_t v;
    v = vec;
    for (int k = 0; k < ResMax; k++) begin
      if (cnt == CntW'(k)) begin
        v[k] = r;
      end
    end
    put_res = v;
  endfunction

endpackage

// File: rtl/cwsn_step.sv
// per-word decision logic: result list and next state for one character
module cwsn_step (
  input  logic [7:0]                       char_i,
  input  logic                             final_i,
  input  cwsn_pkg::state_t                 st_i,
  output cwsn_pkg::res_vec_t               res_o,
  output logic [cwsn_pkg::CntW-1:0]        cnt_o,
  output cwsn_pkg::state_t                 st_o
);
  import cwsn_pkg::*;

  always_comb begin
    state_t           s;
    res_vec_t         v;
    logic [CntW-1:0]  n;
    res_t             r;
    s = st_i;
    v = '0;
    n = '0;
    r = '0;

    if (is_delim(char_i)) begin
      // close word: flush a held zero after any pending space, then mark a space pending once output exists
      if (s.zero_pending) begin
        if (s.space_pending) begin
          r = '{out_char: ChSpace, char_valid: 1'b1, end_of_string: 1'b0};
          v = put_res(v, n, r);
          n = n + 1'b1;
          s.space_pending = 1'b0;
        end
        r = '{out_char: ChZero, char_valid: 1'b1, end_of_string: 1'b0};
        v = put_res(v, n, r);
        n = n + 1'b1;
        s.had_output   = 1'b1;
        s.zero_pending = 1'b0;
      end
      s.at_word_start = 1'b1;
      if (s.had_output) begin
        s.space_pending = 1'b1;
      end
    end else if (s.at_word_start && (char_i == ChZero)) begin
      s.zero_pending = 1'b1;
    end else begin
      if (s.space_pending) begin
        r = '{out_char: ChSpace, char_valid: 1'b1, end_of_string: 1'b0};
        v = put_res(v, n, r);
        n = n + 1'b1;
        s.space_pending = 1'b0;
      end
      r = '{out_char: char_i, char_valid: 1'b1, end_of_string: 1'b0};
      v = put_res(v, n, r);
      n = n + 1'b1;
      s.had_output    = 1'b1;
      s.zero_pending  = 1'b0;
      s.at_word_start = 1'b0;
    end

    if (final_i) begin
      if (s.zero_pending) begin
        if (s.space_pending) begin
          r = '{out_char: ChSpace, char_valid: 1'b1, end_of_string: 1'b0};
          v = put_res(v, n, r);
          n = n + 1'b1;
        end
        r = '{out_char: ChZero, char_valid: 1'b1, end_of_string: 1'b0};
        v = put_res(v, n, r);
        n = n + 1'b1;
      end
      r = '{out_char: 8'h00, char_valid: 1'b0, end_of_string: 1'b1};
      v = put_res(v, n, r);
      n = n + 1'b1;
      s = StateReset;
    end

    res_o = v;
    cnt_o = n;
    st_o  = s;
  end

endmodule

// File: rtl/cwsn_outbuf.sv
// result register holding the results of one word, drained one per cycle while out_ready_i is high
module cwsn_outbuf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  cwsn_pkg::res_vec_t         res_i,
  input  logic [cwsn_pkg::CntW-1:0]  cnt_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_char_o,
  output logic                       char_valid_o,
  output logic                       end_of_string_o
);
  import cwsn_pkg::*;

  res_vec_t        buf_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            take;
  logic            last_take;
  res_t            head;

  assign out_valid_o = (idx_q != cnt_q);
  assign take        = out_valid_o && out_ready_i;
  assign last_take   = take && ((idx_q + 1'b1) == cnt_q);
  assign free_o      = !out_valid_o || last_take;

  always_comb begin
    head = '0;
    for (int k = 0; k < ResMax; k++) begin
      if (idx_q == CntW'(k)) begin
        head = buf_q[k];
      end
    end
  end

  assign out_char_o      = head.out_char;
  assign char_valid_o    = head.char_valid;
  assign end_of_string_o = head.end_of_string;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = cnt_i;
      idx_d = '0;
    end else if (take) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= res_i;
    end
  end

endmodule

// File: rtl/code_word_string_normalizer.sv
// top level: input register, normalizer state and result register
// a word goes from the input register to the result register, which shows its first result
// throughput: one word per cycle while each word yields at most one result and the output is ready
// a word with two or three results holds back the next word until its last result is taken
// reset clears the input valid flag and the result count and index and returns to the start of a string
module code_word_string_normalizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       final_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       end_of_string_o
);
  import cwsn_pkg::*;

  logic            in_vld_q, in_vld_d;
  logic [7:0]      char_q;
  logic            final_q;
  state_t          st_q, st_d;
  res_vec_t        res;
  logic [CntW-1:0] cnt;
  state_t          st_next;
  logic            free;
  logic            advance;
  logic            accept;

  cwsn_step u_step (
    .char_i  (char_q),
    .final_i (final_q),
    .st_i    (st_q),
    .res_o   (res),
    .cnt_o   (cnt),
    .st_o    (st_next)
  );

  assign advance    = in_vld_q && ((cnt == '0) || free);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  cwsn_outbuf u_outbuf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && (cnt != '0)),
    .res_i           (res),
    .cnt_i           (cnt),
    .free_o          (free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .char_valid_o    (char_valid_o),
    .end_of_string_o (end_of_string_o)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    st_d     = st_q;
    if (advance) begin
      st_d     = st_next;
      in_vld_d = 1'b0;
    end
    if (accept) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= StateReset;
    end else begin
      in_vld_q <= in_vld_d;
      st_q     <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q  <= in_char_i;
      final_q <= final_char_i;
    end
  end

endmodule
